/* rtl/ale_pkg.sv */
// Shared types and constants for the array list engine.
// No dependencies; imported by every module of the block except ale_ram.
package ale_pkg;

  localparam int DEPTH   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KIND_W  = 3;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 37;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int SUM_W   = DATA_W + CNT_W;
  localparam int ACC_W   = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W + 1;

  localparam logic signed [ACC_W-1:0] TOTAL_MAX = ACC_W'((65'sd1 <<< (TOTAL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] TOTAL_MIN = -TOTAL_MAX - ACC_W'(1);

  typedef enum logic [KIND_W-1:0] {
    K_INSERT  = 3'd0,
    K_DELETE  = 3'd1,
    K_SEARCH  = 3'd2,
    K_READ    = 3'd3,
    K_SUMMARY = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic len_zero;
    logic len_one;
  } stat_t;

endpackage

/* rtl/ale_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ale_ctrl.sv */
// Sequencer for the array list engine: load, walk the stored elements, finish.
// Depends on ale_pkg.
module ale_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ale_pkg::stat_t stat,
  output ale_pkg::cmd_t  cmd,
  output logic          busy
);
  import ale_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // one RAM read per cycle until the walk length is used up
        if (stat.len_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.issue = 1'b1;
          if (stat.len_one) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/ale_dpath.sv */
// Datapath: element RAM, count, walk pointer, search/summary logic, result registers.
// Depends on ale_pkg and ale_ram.
module ale_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ale_pkg::cmd_t                        cmd,
  output ale_pkg::stat_t                       stat,
  input  logic [ale_pkg::KIND_W-1:0]           in_kind,
  input  logic [ale_pkg::POS_W-1:0]            in_position,
  input  logic signed [ale_pkg::DATA_W-1:0]    in_operand_value,
  output logic                                 out_valid,
  output logic [ale_pkg::STAT_W-1:0]           out_status,
  output logic [ale_pkg::POS_W-1:0]            out_found_index,
  output logic signed [ale_pkg::DATA_W-1:0]    out_element_value,
  output logic signed [ale_pkg::DATA_W-1:0]    out_largest,
  output logic signed [ale_pkg::DATA_W-1:0]    out_smallest,
  output logic signed [ale_pkg::TOTAL_W-1:0]   out_total,
  output logic [ale_pkg::POS_W-1:0]            out_element_count,
  output logic                                 out_last
);
  import ale_pkg::*;

  // request registers
  logic [KIND_W-1:0]        kind_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;
  status_t                  st_r;
  logic [CNT_W-1:0]         cnt_r;

  // walk state
  logic [CNT_W-1:0]         len_r;
  logic [ADDR_W-1:0]        ptr_r;
  logic                     up_r;
  logic                     rvalid_r;
  logic [ADDR_W-1:0]        rtag_r;

  // scan results
  logic                     pend_r;
  logic [ADDR_W-1:0]        pend_idx_r;
  logic signed [DATA_W-1:0] rd_val_r;
  logic signed [DATA_W-1:0] max_r;
  logic signed [DATA_W-1:0] min_r;
  logic signed [ACC_W-1:0]  sum_r;

  // result registers
  logic                     out_valid_r;
  logic [STAT_W-1:0]        o_status_r;
  logic [POS_W-1:0]         o_idx_r;
  logic signed [DATA_W-1:0] o_elem_r;
  logic signed [DATA_W-1:0] o_max_r;
  logic signed [DATA_W-1:0] o_min_r;
  logic signed [TOTAL_W-1:0] o_total_r;
  logic [POS_W-1:0]         o_cnt_r;
  logic                     o_last_r;

  // load decode
  status_t                  ld_st;
  logic [CNT_W-1:0]         ld_len;
  logic [ADDR_W-1:0]        ld_addr;
  logic                     ld_up;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;

  // RAM
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_s;

  logic                     hit;
  logic                     emit_hit;
  logic [CNT_W-1:0]         cnt_nxt;
  logic signed [ACC_W-1:0]  sum_sat;

  // result next values
  logic                     o_valid_nxt;
  logic [STAT_W-1:0]        o_status_nxt;
  logic [POS_W-1:0]         o_idx_nxt;
  logic signed [DATA_W-1:0] o_elem_nxt;
  logic signed [DATA_W-1:0] o_max_nxt;
  logic signed [DATA_W-1:0] o_min_nxt;
  logic signed [TOTAL_W-1:0] o_total_nxt;
  logic [POS_W-1:0]         o_cnt_nxt;
  logic                     o_last_nxt;

  assign pos_x = CMP_W'(in_position);
  assign cnt_x = CMP_W'(cnt_r);

  // bounds checks and walk range, taken at accept
  always_comb begin
    ld_st   = ST_OK;
    ld_len  = '0;
    ld_addr = '0;
    ld_up   = 1'b1;
    case (kind_t'(in_kind))
      K_INSERT: begin
        if (pos_x > cnt_x) begin
          ld_st = ST_RANGE;
        end else if (cnt_r == CNT_W'(DEPTH)) begin
          ld_st = ST_FULL;
        end else begin
          // move entries pos..count-1 up by one, walking from the top
          ld_len  = cnt_r - CNT_W'(in_position);
          ld_addr = ADDR_W'(cnt_r - CNT_W'(1));
          ld_up   = 1'b0;
        end
      end
      K_DELETE: begin
        if (cnt_r == '0) begin
          ld_st = ST_MISS;
        end else if (pos_x >= cnt_x) begin
          ld_st = ST_RANGE;
        end else begin
          ld_len  = cnt_r - CNT_W'(in_position) - CNT_W'(1);
          ld_addr = ADDR_W'(in_position) + ADDR_W'(1);
        end
      end
      K_SEARCH: begin
        ld_len = cnt_r;
      end
      K_READ: begin
        if (cnt_r == '0) begin
          ld_st = ST_MISS;
        end else if (pos_x >= cnt_x) begin
          ld_st = ST_RANGE;
        end else begin
          ld_len  = CNT_W'(1);
          ld_addr = ADDR_W'(in_position);
        end
      end
      K_SUMMARY: begin
        if (cnt_r == '0) begin
          ld_st = ST_MISS;
        end else begin
          ld_len = cnt_r;
        end
      end
      default: begin
        ld_st = ST_RANGE;
      end
    endcase
  end

  assign stat.len_zero = (len_r == '0);
  assign stat.len_one  = (len_r == CNT_W'(1));

  assign rd_s     = ram_rdata;
  assign hit      = rvalid_r && (kind_t'(kind_r) == K_SEARCH) && (rd_s == val_r);
  // a new hit releases the one held back; the held one is the last only at the end
  assign emit_hit = hit && pend_r;

  // RAM write port: shifted element during the walk, new element at finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rtag_r;
    ram_wdata = ram_rdata;
    if (rvalid_r && (kind_t'(kind_r) == K_INSERT)) begin
      ram_we    = 1'b1;
      ram_waddr = rtag_r + ADDR_W'(1);
    end else if (rvalid_r && (kind_t'(kind_r) == K_DELETE)) begin
      ram_we    = 1'b1;
      ram_waddr = rtag_r - ADDR_W'(1);
    end else if (cmd.finish && (kind_t'(kind_r) == K_INSERT) && (st_r == ST_OK)) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(pos_r);
      ram_wdata = val_r;
    end
  end

  ale_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.finish && (st_r == ST_OK)) begin
      if (kind_t'(kind_r) == K_INSERT) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (kind_t'(kind_r) == K_DELETE) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (sum_r > TOTAL_MAX) begin
      sum_sat = TOTAL_MAX;
    end else if (sum_r < TOTAL_MIN) begin
      sum_sat = TOTAL_MIN;
    end else begin
      sum_sat = sum_r;
    end
  end

  // result formatting
  always_comb begin
    o_valid_nxt  = emit_hit || cmd.finish;
    o_status_nxt = st_r;
    o_idx_nxt    = pos_r;
    o_elem_nxt   = '0;
    o_max_nxt    = '0;
    o_min_nxt    = '0;
    o_total_nxt  = '0;
    o_cnt_nxt    = POS_W'(cnt_nxt);
    o_last_nxt   = 1'b1;
    if (emit_hit) begin
      o_status_nxt = ST_OK;
      o_idx_nxt    = POS_W'(pend_idx_r);
      o_elem_nxt   = val_r;
      o_last_nxt   = 1'b0;
    end else begin
      case (kind_t'(kind_r))
        K_SEARCH: begin
          if (pend_r) begin
            o_status_nxt = ST_OK;
            o_idx_nxt    = POS_W'(pend_idx_r);
            o_elem_nxt   = val_r;
          end else begin
            o_status_nxt = ST_MISS;
            o_idx_nxt    = '0;
          end
        end
        K_READ: begin
          if (st_r == ST_OK) begin
            o_elem_nxt = rd_val_r;
          end
        end
        K_SUMMARY: begin
          if (st_r == ST_OK) begin
            o_max_nxt   = max_r;
            o_min_nxt   = min_r;
            o_total_nxt = TOTAL_W'(sum_sat);
          end
        end
        default: begin
          o_elem_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      len_r       <= '0;
      rvalid_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rvalid_r    <= cmd.issue;
      out_valid_r <= o_valid_nxt;
      if (cmd.load) begin
        len_r  <= ld_len;
        pend_r <= 1'b0;
      end else if (cmd.issue) begin
        len_r <= len_r - CNT_W'(1);
      end
      if (hit) begin
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      pos_r  <= in_position;
      val_r  <= in_operand_value;
      st_r   <= ld_st;
      ptr_r  <= ld_addr;
      up_r   <= ld_up;
      sum_r  <= '0;
    end else if (cmd.issue) begin
      ptr_r <= up_r ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
    end
    if (cmd.issue) begin
      rtag_r <= ptr_r;
    end
    if (hit) begin
      pend_idx_r <= rtag_r;
    end
    if (rvalid_r && (kind_t'(kind_r) == K_READ)) begin
      rd_val_r <= rd_s;
    end
    if (rvalid_r && (kind_t'(kind_r) == K_SUMMARY)) begin
      sum_r <= sum_r + ACC_W'(rd_s);
      // summary walks from entry zero, which seeds min and max
      if ((rtag_r == '0) || (rd_s > max_r)) begin
        max_r <= rd_s;
      end
      if ((rtag_r == '0) || (rd_s < min_r)) begin
        min_r <= rd_s;
      end
    end
    if (o_valid_nxt) begin
      o_status_r <= o_status_nxt;
      o_idx_r    <= o_idx_nxt;
      o_elem_r   <= o_elem_nxt;
      o_max_r    <= o_max_nxt;
      o_min_r    <= o_min_nxt;
      o_total_r  <= o_total_nxt;
      o_cnt_r    <= o_cnt_nxt;
      o_last_r   <= o_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_found_index   = o_idx_r;
  assign out_element_value = o_elem_r;
  assign out_largest       = o_max_r;
  assign out_smallest      = o_min_r;
  assign out_total         = o_total_r;
  assign out_element_count = o_cnt_r;
  assign out_last          = o_last_r;

endmodule

/* rtl/array_list_engine.sv */
// Top level of the array list engine: controller plus datapath.
// Depends on ale_pkg, ale_ctrl, ale_dpath (and through it ale_ram).
//
//   channel   direction  handshake          payload
//   in_       input      start / busy       in_kind, in_position, in_operand_value
//   out_      output     out_valid strobe   out_status .. out_last (8 fields)
//
// An item walks N stored elements, one RAM read per cycle: N = count for search
// and summary, count - position for insert, count - position - 1 for delete,
// 1 for read, 0 for a rejected item. busy stays high through run, drain (N > 0)
// and finish states; the final result strobes in the cycle busy drops.
// Search hits strobe during the walk, one per cycle at most.
// rst_n is synchronous; reset empties the list. Results cannot be stalled.
module array_list_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ale_pkg::KIND_W-1:0]           in_kind,
  input  logic [ale_pkg::POS_W-1:0]            in_position,
  input  logic signed [ale_pkg::DATA_W-1:0]    in_operand_value,
  output logic                                 out_valid,
  output logic [ale_pkg::STAT_W-1:0]           out_status,
  output logic [ale_pkg::POS_W-1:0]            out_found_index,
  output logic signed [ale_pkg::DATA_W-1:0]    out_element_value,
  output logic signed [ale_pkg::DATA_W-1:0]    out_largest,
  output logic signed [ale_pkg::DATA_W-1:0]    out_smallest,
  output logic signed [ale_pkg::TOTAL_W-1:0]   out_total,
  output logic [ale_pkg::POS_W-1:0]            out_element_count,
  output logic                                 out_last
);
  import ale_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ale_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ale_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_element_value (out_element_value),
    .out_largest       (out_largest),
    .out_smallest      (out_smallest),
    .out_total         (out_total),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last))
    else $error("item finished without a final result");

  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (busy && (out_status == ST_OK)))
    else $error("intermediate result outside a search walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element_count <= POS_W'(DEPTH)))
    else $error("element count above depth");

endmodule

/* tb/tb_array_list_engine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for array_list_engine: insert, delete, search, read, summary.
// Depends on ale_pkg and the array_list_engine RTL; the scoreboard keeps its own list copy.
module tb_array_list_engine;
  import ale_pkg::*;

  localparam int N_ITEMS   = 270;
  localparam int QUIET_TAIL = 40;
  localparam int LIMIT     = 300000;
  localparam logic signed [63:0] TOTAL_HI = (64'sd1 <<< (TOTAL_W - 1)) - 1;
  localparam logic signed [63:0] TOTAL_LO = -(64'sd1 <<< (TOTAL_W - 1));
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  // value sources for a fill phase
  localparam int VAL_RANDOM = 0;
  localparam int VAL_POOL   = 1;
  localparam int VAL_MAX    = 2;
  localparam int VAL_MIN    = 3;

  typedef struct {
    status_t                    status;
    logic [POS_W-1:0]           index;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   largest;
    logic signed [DATA_W-1:0]   smallest;
    logic signed [TOTAL_W-1:0]  total;
    logic [POS_W-1:0]           count;
    logic                       last;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] elems [DEPTH];
    int count;
    int errors;
    list_result_t pending_results[$];

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void push_result(status_t st, logic [POS_W-1:0] idx,
                              logic signed [DATA_W-1:0] ev,
                              logic signed [DATA_W-1:0] mx,
                              logic signed [DATA_W-1:0] mn,
                              logic signed [TOTAL_W-1:0] tot, logic lst);
      list_result_t r;
      r.status   = st;
      r.index    = idx;
      r.value    = ev;
      r.largest  = mx;
      r.smallest = mn;
      r.total    = tot;
      r.count    = POS_W'(count);
      r.last     = lst;
      pending_results.push_back(r);
    endfunction

    // Update the list copy and queue the results this item produces.
    function void apply_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
      int hits[$];
      logic signed [DATA_W-1:0] mx;
      logic signed [DATA_W-1:0] mn;
      logic signed [63:0] acc;
      case (kind)
        K_INSERT: begin
          if (pos > count) push_result(ST_RANGE, pos, 0, 0, 0, 0, 1'b1);
          else if (count >= DEPTH) push_result(ST_FULL, pos, 0, 0, 0, 0, 1'b1);
          else begin
            for (int i = count; i > pos; i--) elems[i] = elems[i-1];
            elems[ADDR_W'(pos)] = val;
            count++;
            push_result(ST_OK, pos, 0, 0, 0, 0, 1'b1);
          end
        end
        K_DELETE: begin
          if (count == 0) push_result(ST_MISS, pos, 0, 0, 0, 0, 1'b1);
          else if (pos >= count) push_result(ST_RANGE, pos, 0, 0, 0, 0, 1'b1);
          else begin
            for (int i = pos; i + 1 < count; i++) elems[i] = elems[i+1];
            count--;
            push_result(ST_OK, pos, 0, 0, 0, 0, 1'b1);
          end
        end
        K_SEARCH: begin
          for (int i = 0; i < count; i++)
            if (elems[i] == val) hits.push_back(i);
          if (hits.size() == 0) push_result(ST_MISS, 0, 0, 0, 0, 0, 1'b1);
          else begin
            foreach (hits[k])
              push_result(ST_OK, POS_W'(hits[k]), val, 0, 0, 0, k == hits.size() - 1);
          end
        end
        K_READ: begin
          if (count == 0) push_result(ST_MISS, pos, 0, 0, 0, 0, 1'b1);
          else if (pos >= count) push_result(ST_RANGE, pos, 0, 0, 0, 0, 1'b1);
          else push_result(ST_OK, pos, elems[ADDR_W'(pos)], 0, 0, 0, 1'b1);
        end
        K_SUMMARY: begin
          if (count == 0) push_result(ST_MISS, pos, 0, 0, 0, 0, 1'b1);
          else begin
            mx = elems[0];
            mn = elems[0];
            acc = 0;
            for (int i = 0; i < count; i++) begin
              if (elems[i] > mx) mx = elems[i];
              if (elems[i] < mn) mn = elems[i];
              acc += 64'(elems[i]);
            end
            if (acc > TOTAL_HI) acc = TOTAL_HI;
            if (acc < TOTAL_LO) acc = TOTAL_LO;
            push_result(ST_OK, pos, 0, mx, mn, acc[TOTAL_W-1:0], 1'b1);
          end
        end
        default: push_result(ST_RANGE, pos, 0, 0, 0, 0, 1'b1);
      endcase
    endfunction

    function void compare_field(string nm, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [POS_W-1:0] idx,
                               logic signed [DATA_W-1:0] ev,
                               logic signed [DATA_W-1:0] mx,
                               logic signed [DATA_W-1:0] mn,
                               logic signed [TOTAL_W-1:0] tot,
                               logic [POS_W-1:0] cnt, logic lst);
      list_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d index %0d",
                 $time, st, idx);
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", e.status, st);
      compare_field("found_index", e.index, idx);
      compare_field("element_value", e.value, ev);
      compare_field("largest", e.largest, mx);
      compare_field("smallest", e.smallest, mn);
      compare_field("total", e.total, tot);
      compare_field("element_count", e.count, cnt);
      compare_field("last", e.last, lst);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [KIND_W-1:0]          in_kind;
  logic [POS_W-1:0]           in_position;
  logic signed [DATA_W-1:0]   in_operand_value;
  logic                       out_valid;
  logic [STAT_W-1:0]          out_status;
  logic [POS_W-1:0]           out_found_index;
  logic signed [DATA_W-1:0]   out_element_value;
  logic signed [DATA_W-1:0]   out_largest;
  logic signed [DATA_W-1:0]   out_smallest;
  logic signed [TOTAL_W-1:0]  out_total;
  logic [POS_W-1:0]           out_element_count;
  logic                       out_last;

  list_scoreboard sb;
  int  sent;
  bit  idle_enable;
  int  cycles;

  array_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_element_value (out_element_value),
    .out_largest       (out_largest),
    .out_smallest      (out_smallest),
    .out_total         (out_total),
    .out_element_count (out_element_count),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_array_list_engine: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_found_index, out_element_value, out_largest,
                      out_smallest, out_total, out_element_count, out_last);
  end

  // Random sender gap after an accepted item; none near the end of the run.
  task automatic pause();
    if (idle_enable && sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                       input logic signed [DATA_W-1:0] val);
    in_kind          <= kind;
    in_position      <= pos;
    in_operand_value <= val;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    sb.apply_request(kind, pos, val);
    sent++;
    pause();
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(int flavor);
    logic signed [DATA_W-1:0] v;
    case (flavor)
      VAL_POOL: begin
        v = $urandom_range(0, 3);
        v = v - 1;
      end
      VAL_MAX: v = MAX_VAL;
      VAL_MIN: v = MIN_VAL;
      VAL_RANDOM: v = $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Grow toward a full list or shrink toward an empty one, with lookups mixed in.
  task automatic run_phase(input bit grow, input int flavor);
    int r;
    int p_main;
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0] p;
    logic signed [DATA_W-1:0] v;
    p_main = (grow && flavor >= VAL_MAX) ? 85 : 65;
    idle_enable = ($urandom_range(0, 3) != 0);
    while (sent < N_ITEMS && (grow ? sb.count < DEPTH : sb.count > 0)) begin
      r = $urandom_range(0, 99);
      v = pick_value(flavor);
      if (r < 7) begin
        k = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
        p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        v = $urandom;
      end else if (r < 7 + p_main) begin
        if (grow) begin
          k = K_INSERT;
          p = POS_W'($urandom_range(0, sb.count));
        end else begin
          k = K_DELETE;
          p = POS_W'($urandom_range(0, sb.count - 1));
        end
      end else if (r < 12 + p_main) begin
        k = grow ? K_DELETE : K_INSERT;
        p = POS_W'($urandom_range(0, sb.count));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            k = K_SEARCH;
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            if (sb.count > 0 && $urandom_range(0, 1) == 1)
              v = sb.elems[ADDR_W'($urandom_range(0, sb.count - 1))];
          end
          1: begin
            k = K_READ;
            p = POS_W'($urandom_range(0, sb.count));
          end
          default: begin
            k = K_SUMMARY;
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
          end
        endcase
      end
      issue(k, p, v);
    end
    if (grow && sb.count == DEPTH) begin
      issue(K_INSERT, POS_W'($urandom_range(0, DEPTH)), pick_value(flavor));
      issue(K_SUMMARY, POS_W'($urandom_range(0, DEPTH)), 0);
      issue(K_SEARCH, 0, sb.elems[ADDR_W'($urandom_range(0, DEPTH - 1))]);
    end
  endtask

  initial begin
    int flavor;
    sb = new();
    sent = 0;
    idle_enable = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = K_INSERT;
    in_position = '0;
    in_operand_value = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every kind that needs an element reports a miss
    issue(K_SUMMARY, 6'd5, 0);
    issue(K_READ, 6'd0, 0);
    issue(K_DELETE, 6'd0, 0);
    issue(K_SEARCH, 6'd0, 0);
    issue(K_INSERT, 6'd1, 32'sd9);
    // end, beginning and middle inserts with extreme values
    issue(K_INSERT, 6'd0, MAX_VAL);
    issue(K_INSERT, 6'd1, MIN_VAL);
    issue(K_INSERT, 6'd0, 0);
    issue(K_INSERT, 6'd1, MAX_VAL);
    issue(K_SEARCH, 6'd63, MAX_VAL);
    issue(K_SEARCH, 6'd0, MIN_VAL);
    issue(K_SEARCH, 6'd0, 32'sd12345);
    issue(K_READ, 6'd3, 0);
    issue(K_READ, 6'd4, 0);
    issue(K_READ, 6'd63, 0);
    issue(K_INSERT, 6'd63, -32'sd1);
    issue(K_SUMMARY, 6'd63, 0);
    for (int k = K_SUMMARY + 1; k < (1 << KIND_W); k++)
      issue(KIND_W'(k), 6'd63, -32'sd1);
    issue(K_DELETE, 6'd4, 0);
    issue(K_DELETE, 6'd3, 0);
    issue(K_DELETE, 6'd0, 0);
    issue(K_SUMMARY, 6'd0, 0);
    settle();

    flavor = VAL_POOL;
    while (sent < N_ITEMS) begin
      run_phase(1'b1, flavor);
      run_phase(1'b0, flavor);
      if (flavor == VAL_POOL) settle();
      flavor = (flavor + 1) % 4;
    end

    settle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_array_list_engine: PASS");
    end else begin
      $display("tb_array_list_engine: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/ale_ctrl.sv
rtl/ale_dpath.sv
rtl/array_list_engine.sv
tb/tb_array_list_engine.sv
